### src/atsm_pkg.sv
// Package for the affine texture span mapper: command codes, transaction payload
// types and default sizes. It is used by the channel interfaces and the span mapper module.
`default_nettype none
package atsm_pkg;

    localparam int TEX_WORDS_DEFAULT = 4096;
    localparam int MAX_SPAN_DEFAULT  = 512;

    localparam int COORD_W     = 32;
    localparam int FRAC_W      = 16;
    localparam int SIDE_BITS   = 6;
    localparam int ADDR_W      = 12;
    localparam int TEXEL_W     = 8;
    localparam int SPAN_W      = 9;
    localparam int LIGHT_DEPTH = 256;

    localparam logic [ADDR_W-1:0] MASK_RESET = '1;

    typedef enum logic [1:0] {
        CMD_LOAD_TEXEL = 2'd0,
        CMD_LOAD_LIGHT = 2'd1,
        CMD_START_SPAN = 2'd2,
        CMD_STEP_PIXEL = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                       command;
        logic        [ADDR_W-1:0]   address;
        logic        [TEXEL_W-1:0]  data;
        logic signed [COORD_W-1:0]  start_u;
        logic signed [COORD_W-1:0]  start_v;
        logic signed [COORD_W-1:0]  step_u;
        logic signed [COORD_W-1:0]  step_v;
        logic        [SPAN_W-1:0]   span_width;
        logic                       lit;
        logic                       transparent;
    } req_t;

    typedef struct packed {
        logic [TEXEL_W-1:0] color;
        logic               write_enable;
        logic [SPAN_W-1:0]  pixel_offset;
        logic               last;
    } pix_t;

endpackage
`default_nettype wire

### src/atsm_req_if.sv
// Command channel of the span mapper: valid, ready and one command transaction.
// Depends on atsm_pkg for the payload type.
`default_nettype none
interface atsm_req_if;
    logic            valid;
    logic            ready;
    atsm_pkg::req_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### src/atsm_pix_if.sv
// Pixel channel of the span mapper: valid, ready and one pixel transaction.
// Depends on atsm_pkg for the payload type.
`default_nettype none
interface atsm_pix_if;
    logic            valid;
    logic            ready;
    atsm_pkg::pix_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### src/atsm_ram.sv
// Single-port-write, single-port-read RAM with a registered, enabled read.
// Holds the texture store and the light colormap; no package dependency.
`default_nettype none
module atsm_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### src/affine_texture_span_mapper.sv
// Affine texture span mapper: one pixel per step command on an active span, texel fetch then colormap.
// A pixel is registered in stage s1, then in stage s2, which drives the pixel channel.
// Throughput: one command per cycle; the whole pipeline holds while a pixel waits.
// The texture RAM read and the colormap RAM read each take one registered stage.
// Reset clears the span state and the pipeline; the RAMs are not cleared.
// Depends on atsm_pkg, atsm_req_if, atsm_pix_if and atsm_ram; TEX_WORDS is a power of two.
`default_nettype none
module affine_texture_span_mapper #(
    parameter int TEX_WORDS = atsm_pkg::TEX_WORDS_DEFAULT,
    parameter int MAX_SPAN  = atsm_pkg::MAX_SPAN_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [atsm_pkg::ADDR_W-1:0] cfg_wdata,
    atsm_req_if.sink                         req,
    atsm_pix_if.source                       pix
);

    localparam int TEX_AW   = $clog2(TEX_WORDS);
    localparam int LIGHT_AW = $clog2(atsm_pkg::LIGHT_DEPTH);
    localparam int SPAN_TOP = (1 << atsm_pkg::SPAN_W) - 1;
    localparam int SPAN_CAP = (MAX_SPAN < SPAN_TOP) ? MAX_SPAN : SPAN_TOP;
    localparam int U_LSB    = atsm_pkg::FRAC_W;
    localparam int U_MSB    = atsm_pkg::FRAC_W + atsm_pkg::SIDE_BITS - 1;

    logic [atsm_pkg::ADDR_W-1:0]  texel_mask_reg;
    logic [atsm_pkg::COORD_W-1:0] cur_u_reg, cur_u_next;
    logic [atsm_pkg::COORD_W-1:0] cur_v_reg, cur_v_next;
    logic [atsm_pkg::COORD_W-1:0] delta_u_reg, delta_u_next;
    logic [atsm_pkg::COORD_W-1:0] delta_v_reg, delta_v_next;
    logic [atsm_pkg::SPAN_W-1:0]  left_reg, left_next;
    logic                         lit_reg, lit_next;
    logic                         transp_reg, transp_next;

    logic                         s1_valid_reg, s1_valid_next;
    logic [atsm_pkg::SPAN_W-1:0]  s1_offset_reg;
    logic                         s1_last_reg;
    logic                         s1_lit_reg;
    logic                         s1_transp_reg;

    logic                         s2_valid_reg;
    logic [atsm_pkg::SPAN_W-1:0]  s2_offset_reg;
    logic                         s2_last_reg;
    logic                         s2_lit_reg;
    logic                         s2_transp_reg;
    logic [atsm_pkg::TEXEL_W-1:0] s2_tex_reg;

    logic                         advance;
    logic                         accept;
    logic                         active;
    logic                         is_step;
    logic [atsm_pkg::SPAN_W-1:0]  width_sat;
    logic [atsm_pkg::ADDR_W-1:0]  tex_idx;
    logic                         tex_we;
    logic                         light_we;
    logic [atsm_pkg::TEXEL_W-1:0] tex_rdata;
    logic [atsm_pkg::TEXEL_W-1:0] light_rdata;

    assign advance  = !s2_valid_reg || pix.ready;
    assign req.ready = advance;
    assign accept   = req.valid && advance;
    assign active   = (left_reg != '0);
    assign is_step  = (req.payload.command == atsm_pkg::CMD_STEP_PIXEL);
    assign tex_we   = accept && (req.payload.command == atsm_pkg::CMD_LOAD_TEXEL);
    assign light_we = accept && (req.payload.command == atsm_pkg::CMD_LOAD_LIGHT);
    assign tex_idx  = {cur_u_reg[U_MSB:U_LSB], cur_v_reg[U_MSB:U_LSB]} & texel_mask_reg;
    assign width_sat = (req.payload.span_width > atsm_pkg::SPAN_W'(SPAN_CAP))
                     ? atsm_pkg::SPAN_W'(SPAN_CAP) : req.payload.span_width;

    always_comb
    begin
        cur_u_next    = cur_u_reg;
        cur_v_next    = cur_v_reg;
        delta_u_next  = delta_u_reg;
        delta_v_next  = delta_v_reg;
        left_next     = left_reg;
        lit_next      = lit_reg;
        transp_next   = transp_reg;
        s1_valid_next = 1'b0;
        if (accept)
        begin
            case (req.payload.command)
                atsm_pkg::CMD_START_SPAN:
                begin
                    cur_u_next   = req.payload.start_u;
                    cur_v_next   = req.payload.start_v;
                    delta_u_next = req.payload.step_u;
                    delta_v_next = req.payload.step_v;
                    left_next    = width_sat;
                    lit_next     = req.payload.lit;
                    transp_next  = req.payload.transparent;
                end
                atsm_pkg::CMD_STEP_PIXEL:
                begin
                    if (active)
                    begin
                        cur_u_next    = cur_u_reg + delta_u_reg;
                        cur_v_next    = cur_v_reg + delta_v_reg;
                        left_next     = left_reg - atsm_pkg::SPAN_W'(1);
                        s1_valid_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            texel_mask_reg <= atsm_pkg::MASK_RESET;
            cur_u_reg      <= '0;
            cur_v_reg      <= '0;
            delta_u_reg    <= '0;
            delta_v_reg    <= '0;
            left_reg       <= '0;
            lit_reg        <= 1'b0;
            transp_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                texel_mask_reg <= cfg_wdata;
            end
            cur_u_reg   <= cur_u_next;
            cur_v_reg   <= cur_v_next;
            delta_u_reg <= delta_u_next;
            delta_v_reg <= delta_v_next;
            left_reg    <= left_next;
            lit_reg     <= lit_next;
            transp_reg  <= transp_next;
            if (advance)
            begin
                s1_valid_reg <= s1_valid_next;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_offset_reg <= left_reg - atsm_pkg::SPAN_W'(1);
            s1_last_reg   <= (left_reg == atsm_pkg::SPAN_W'(1));
            s1_lit_reg    <= lit_reg;
            s1_transp_reg <= transp_reg;
            s2_offset_reg <= s1_offset_reg;
            s2_last_reg   <= s1_last_reg;
            s2_lit_reg    <= s1_lit_reg;
            s2_transp_reg <= s1_transp_reg;
            s2_tex_reg    <= tex_rdata;
        end
    end

    atsm_ram #(
        .DEPTH (TEX_WORDS),
        .WIDTH (atsm_pkg::TEXEL_W)
    ) u_tex_ram (
        .clk     (clk),
        .wr_en   (tex_we),
        .wr_addr (req.payload.address[TEX_AW-1:0]),
        .wr_data (req.payload.data),
        .rd_en   (advance),
        .rd_addr (tex_idx[TEX_AW-1:0]),
        .rd_data (tex_rdata)
    );

    atsm_ram #(
        .DEPTH (atsm_pkg::LIGHT_DEPTH),
        .WIDTH (atsm_pkg::TEXEL_W)
    ) u_light_ram (
        .clk     (clk),
        .wr_en   (light_we),
        .wr_addr (req.payload.address[LIGHT_AW-1:0]),
        .wr_data (req.payload.data),
        .rd_en   (advance),
        .rd_addr (tex_rdata[LIGHT_AW-1:0]),
        .rd_data (light_rdata)
    );

    assign pix.valid                = s2_valid_reg;
    assign pix.payload.color        = s2_lit_reg ? light_rdata : s2_tex_reg;
    assign pix.payload.write_enable = !(s2_transp_reg && (s2_tex_reg == '0));
    assign pix.payload.pixel_offset = s2_offset_reg;
    assign pix.payload.last         = s2_last_reg;

    a_step_enters_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_step && active) |=> s1_valid_reg)
        else $error("Step on an active span did not enter the pipeline.");

    a_idle_step_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_step && !active) |=> (!s1_valid_reg && (left_reg == '0)
            && $stable(cur_u_reg) && $stable(cur_v_reg)))
        else $error("Step with no active span changed the span state.");

    a_last_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.payload.last) |-> (pix.payload.pixel_offset == '0))
        else $error("Last pixel of a span has a nonzero offset.");

endmodule
`default_nettype wire
